// ----- hw/rtl/srb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the stream byte reassembler.
// No dependencies; imported by srb_seq and stream_byte_reassembler.

package srb_pkg;

    // Item kinds carried on the input channel.
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Configuration register map.
    localparam int          CFG_ADDR_W    = 2;
    localparam logic [1:0]  ADDR_CAPACITY = 2'd0;
    localparam int          CAP_W         = 11;
    localparam logic [10:0] CAP_RESET     = 11'd1024;

    // Ring entry: a valid mark above the stored byte.
    localparam int ENTRY_W   = 9;
    localparam int VALID_BIT = 8;

    localparam int COUNT_W = 11;

    // One result item as it leaves the sequencer.
    typedef struct packed {
        logic               out_valid;
        logic [7:0]         out_byte;
        logic               accepted;
        logic [COUNT_W-1:0] unassembled_count;
        logic               stream_done;
    } srb_result_t;

endpackage

// ----- hw/rtl/stream_byte_reassembler.sv -----
`timescale 1ns / 1ps
// Top level of the stream byte reassembler: configuration port, result
// register, sequencer and ring memory. Uses srb_pkg, srb_seq and srb_ram.

// The reassembler takes one item per input transfer (push a byte at an
// absolute offset, read the next assembled byte, or mark the stream end) and
// gives exactly one result transfer for each. The stored bytes live in one
// ring memory of RING_DEPTH entries, each a byte with a valid mark, indexed
// by offset modulo RING_DEPTH; a sequencer reads, modifies and writes it
// back. After reset the block clears the ring, one entry per cycle, and the
// input is stalled until the clear is done; configuration writes are taken
// during that time as always. An item then passes from its input transfer
// through the dispatch state, the push or read state for a stored push or a
// read that returns a byte, the advance walk, which examines ring entries,
// and the emit state, which loads its result into the output register once
// that is free. The walk looks at the entry at the contiguous point and at
// the entry after each byte it steps over, one per cycle through the single
// ring read port, and stops without a look once the contiguous point sits at
// the window edge or at a known end. The next item can be accepted in the
// cycle after the one that loads the result into the output register, so a
// waiting result costs the input side at most the time it stays untaken
// before its successor is finished. Offsets wrap modulo 2^32 and every
// window test is made on the distance from the read position.
// capacity_in_use sets the window in bytes, limited to RING_DEPTH, and
// must only be written while no transfer is in flight.

module stream_byte_reassembler #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,

    // Item channel.
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic [31:0]                    stream_index,
    input  logic [7:0]                     data_byte,

    // Result channel.
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic                           out_valid,
    output logic [7:0]                     out_byte,
    output logic                           accepted,
    output logic [srb_pkg::COUNT_W-1:0]    unassembled_count,
    output logic                           stream_done
);

    import srb_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             cfg_write;
    logic             cap_hit;

    srb_result_t      res_reg, res_next;
    logic             res_valid_reg, res_valid_next;
    srb_result_t      seq_res;
    logic             res_load;
    logic             res_free;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    // The register completes in the access phase; there are no wait states.
    assign pready    = 1'b1;
    assign cap_hit   = (paddr == ADDR_CAPACITY);
    assign cfg_write = psel && penable && pwrite && pready;
    assign cap_next  = (cfg_write && cap_hit) ? pwdata[CAP_W-1:0] : cap_reg;
    assign prdata    = cap_hit ? 32'(cap_reg) : 32'd0;

    // The output register frees up in the same cycle its transfer completes.
    assign res_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_next       = seq_res;
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            cap_reg       <= cap_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign res_valid         = res_valid_reg;
    assign out_valid         = res_reg.out_valid;
    assign out_byte          = res_reg.out_byte;
    assign accepted          = res_reg.accepted;
    assign unassembled_count = res_reg.unassembled_count;
    assign stream_done       = res_reg.stream_done;

    srb_seq #(
        .RING_DEPTH (RING_DEPTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .stream_index (stream_index),
        .data_byte    (data_byte),
        .capacity     (cap_reg),
        .res_free     (res_free),
        .res_load     (res_load),
        .res          (seq_res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    srb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- hw/rtl/srb_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.

module srb_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/srb_seq.sv -----
`timescale 1ns / 1ps
// Sequencer of the stream byte reassembler: window checks, ring
// read-modify-write, the advance walk and the clearing pass. Uses srb_pkg.

module srb_seq #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [31:0]                   stream_index,
    input  logic [7:0]                    data_byte,
    input  logic [srb_pkg::CAP_W-1:0]     capacity,
    input  logic                          res_free,
    output logic                          res_load,
    output srb_pkg::srb_result_t          res,
    output logic                          mem_we,
    output logic [$clog2(RING_DEPTH)-1:0] mem_waddr,
    output logic [srb_pkg::ENTRY_W-1:0]   mem_wdata,
    output logic [$clog2(RING_DEPTH)-1:0] mem_raddr,
    input  logic [srb_pkg::ENTRY_W-1:0]   mem_rdata
);

    import srb_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int PW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(RING_DEPTH);
    localparam logic [31:0]   DEPTH_32  = 32'(RING_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_PUSH,
        S_READ,
        S_ADV_REQ,
        S_ADV_CHK,
        S_EMIT
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [1:0]     kind_reg, kind_next;
    logic [31:0]    idx_reg, idx_next;
    logic [7:0]     data_reg, data_next;
    logic [AW-1:0]  slot_reg, slot_next;
    logic           ov_reg, ov_next;
    logic [7:0]     ob_reg, ob_next;
    logic           acc_reg, acc_next;
    logic [31:0]    nc_reg, nc_next;
    logic [31:0]    rp_reg, rp_next;
    logic [31:0]    end_reg, end_next;
    logic           ek_reg, ek_next;
    logic [PW-1:0]  pend_reg, pend_next;
    logic [AW-1:0]  rp_slot_reg, rp_slot_next;
    logic [AW-1:0]  nc_slot_reg, nc_slot_next;

    logic [31:0]   cap_32, win;
    logic [31:0]   d_idx, d_nc, d_end;
    logic          push_ok;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] push_slot;
    logic [31:0]   nc_inc;
    logic [AW-1:0] nc_slot_inc, rp_slot_inc;
    logic          step_nc, step_inc;
    logic [31:0]   pend_32;

    // All window tests are made on distances from the read position.
    assign cap_32 = 32'(capacity);
    assign win    = (cap_32 > DEPTH_32) ? DEPTH_32 : cap_32;
    assign d_idx  = idx_reg - rp_reg;
    assign d_nc   = nc_reg - rp_reg;
    assign d_end  = end_reg - rp_reg;

    assign push_ok = (d_idx >= d_nc) && (d_idx < win) && !(ek_reg && (d_idx >= d_end));

    // The distance is below the ring depth whenever a push is stored, so
    // one conditional subtract reduces the slot.
    assign slot_sum  = {1'b0, rp_slot_reg} + {1'b0, d_idx[AW-1:0]};
    assign push_slot = (slot_sum >= DEPTH_EXT) ? AW'(slot_sum - DEPTH_EXT) : slot_sum[AW-1:0];

    assign nc_inc      = nc_reg + 32'd1;
    assign nc_slot_inc = (nc_slot_reg == LAST_SLOT) ? '0 : nc_slot_reg + 1'b1;
    assign rp_slot_inc = (rp_slot_reg == LAST_SLOT) ? '0 : rp_slot_reg + 1'b1;

    assign step_nc  = ((nc_reg - rp_reg) < win) && !(ek_reg && (nc_reg == end_reg));
    assign step_inc = ((nc_inc - rp_reg) < win) && !(ek_reg && (nc_inc == end_reg));

    assign pend_32 = 32'(pend_reg);

    assign res.out_valid         = ov_reg;
    assign res.out_byte          = ob_reg;
    assign res.accepted          = acc_reg;
    assign res.unassembled_count = (pend_32 > 32'd2047) ? {COUNT_W{1'b1}} : pend_32[COUNT_W-1:0];
    assign res.stream_done       = ek_reg && (nc_reg == end_reg);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        data_next    = data_reg;
        slot_next    = slot_reg;
        ov_next      = ov_reg;
        ob_next      = ob_reg;
        acc_next     = acc_reg;
        nc_next      = nc_reg;
        rp_next      = rp_reg;
        end_next     = end_reg;
        ek_next      = ek_reg;
        pend_next    = pend_reg;
        rp_slot_next = rp_slot_reg;
        nc_slot_next = nc_slot_reg;
        mem_we       = 1'b0;
        mem_waddr    = nc_slot_reg;
        mem_wdata    = '0;
        mem_raddr    = nc_slot_reg;
        res_load     = 1'b0;
        in_stall     = (state_reg != S_IDLE);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    idx_next   = stream_index;
                    data_next  = data_byte;
                    ov_next    = 1'b0;
                    ob_next    = '0;
                    acc_next   = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_ADV_REQ;
                case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (push_ok)
                        begin
                            mem_raddr  = push_slot;
                            slot_next  = push_slot;
                            acc_next   = 1'b1;
                            state_next = S_PUSH;
                        end
                    end
                    KIND_READ:
                    begin
                        if (nc_reg != rp_reg)
                        begin
                            mem_raddr  = rp_slot_reg;
                            state_next = S_READ;
                        end
                    end
                    KIND_END:
                    begin
                        ek_next  = 1'b1;
                        end_next = (d_idx < d_nc) ? nc_reg : idx_reg;
                    end
                    default:
                    begin
                        state_next = S_ADV_REQ;
                    end
                endcase
            end
            S_PUSH:
            begin
                // A rewrite of an already stored byte leaves the count alone.
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = {1'b1, data_reg};
                if (!mem_rdata[VALID_BIT])
                begin
                    pend_next = pend_reg + 1'b1;
                end
                state_next = S_ADV_REQ;
            end
            S_READ:
            begin
                ov_next      = 1'b1;
                ob_next      = mem_rdata[7:0];
                rp_next      = rp_reg + 32'd1;
                rp_slot_next = rp_slot_inc;
                state_next   = S_ADV_REQ;
            end
            S_ADV_REQ:
            begin
                if (step_nc)
                begin
                    mem_raddr  = nc_slot_reg;
                    state_next = S_ADV_CHK;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_ADV_CHK:
            begin
                // The write goes to the current slot while a continuing walk already reads
                // the following one, so a read that is used never collides with the write.
                if (mem_rdata[VALID_BIT])
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = nc_slot_reg;
                    mem_wdata    = {1'b0, mem_rdata[7:0]};
                    nc_next      = nc_inc;
                    nc_slot_next = nc_slot_inc;
                    if (pend_reg != '0)
                    begin
                        pend_next = pend_reg - 1'b1;
                    end
                    if (step_inc)
                    begin
                        mem_raddr = nc_slot_inc;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            kind_reg    <= KIND_PUSH;
            idx_reg     <= '0;
            data_reg    <= '0;
            slot_reg    <= '0;
            ov_reg      <= 1'b0;
            ob_reg      <= '0;
            acc_reg     <= 1'b0;
            nc_reg      <= '0;
            rp_reg      <= '0;
            end_reg     <= '0;
            ek_reg      <= 1'b0;
            pend_reg    <= '0;
            rp_slot_reg <= '0;
            nc_slot_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            kind_reg    <= kind_next;
            idx_reg     <= idx_next;
            data_reg    <= data_next;
            slot_reg    <= slot_next;
            ov_reg      <= ov_next;
            ob_reg      <= ob_next;
            acc_reg     <= acc_next;
            nc_reg      <= nc_next;
            rp_reg      <= rp_next;
            end_reg     <= end_next;
            ek_reg      <= ek_next;
            pend_reg    <= pend_next;
            rp_slot_reg <= rp_slot_next;
            nc_slot_reg <= nc_slot_next;
        end
    end

endmodule
